// ----- design/sgr_pkg.sv -----
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared constants, result kinds and color tables for the SGR color parser.
// ----------------------------------------------------------------------------
package sgr_pkg;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_FINAL_M  = 8'h6D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SUB      = 8'h7F;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_HIGH     = 8'h80;

  localparam logic [31:0] RESET_FG = 32'hFFA6A6A6;
  localparam logic [31:0] RESET_BG = 32'hFF181818;

  typedef enum logic [1:0] {
    KIND_PRINT = 2'd0,
    KIND_CTRL  = 2'd1,
    KIND_STOP  = 2'd2
  } char_kind_t;

  // Normal palette, shared by the foreground and background codes.
  function automatic logic [31:0] normal_color(input logic [3:0] idx);
    logic [31:0] c;
    case (idx)
      4'd0: c = 32'hFF181818;
      4'd1: c = 32'hFFA61010;
      4'd2: c = 32'hFF10A610;
      4'd3: c = 32'hFFA66010;
      4'd4: c = 32'hFF1010A6;
      4'd5: c = 32'hFFA610A6;
      4'd6: c = 32'hFF10A6A6;
      4'd7: c = 32'hFFA6A6A6;
      default: c = 32'hFFFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] bright_color(input logic [3:0] idx);
    logic [31:0] c;
    case (idx)
      4'd0: c = 32'hFF323232;
      4'd1: c = 32'hFFD01010;
      4'd2: c = 32'hFF10D010;
      4'd3: c = 32'hFFD0D010;
      4'd4: c = 32'hFF1060D0;
      4'd5: c = 32'hFFD010D0;
      4'd6: c = 32'hFF10D0D0;
      4'd7: c = 32'hFFD0D0D0;
      default: c = 32'hFFFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic touches_fg(input logic [7:0] v);
    return v inside {8'd0, [8'd30:8'd38], [8'd90:8'd98]};
  endfunction

  function automatic logic touches_bg(input logic [7:0] v);
    return v inside {8'd0, [8'd40:8'd48]};
  endfunction

  // Foreground selected by a code; the caller only passes codes that touch it.
  function automatic logic [31:0] fg_of(input logic [7:0] v, input logic [31:0] dflt);
    logic [31:0] c;
    logic [7:0]  d;
    d = 8'd0;
    if (v == 8'd0) begin
      c = dflt;
    end else if (v >= 8'd90) begin
      d = v - 8'd90;
      c = bright_color(d[3:0]);
    end else begin
      d = v - 8'd30;
      c = normal_color(d[3:0]);
    end
    return c;
  endfunction

  function automatic logic [31:0] bg_of(input logic [7:0] v, input logic [31:0] dflt);
    logic [31:0] c;
    logic [7:0]  d;
    d = v - 8'd40;
    if (v == 8'd0) begin
      c = dflt;
    end else begin
      c = normal_color(d[3:0]);
    end
    return c;
  endfunction

endpackage

// ----- design/ansi_sgr_color_parser.sv -----
// ----------------------------------------------------------------------------
// ansi_sgr_color_parser
// Byte stream parser for ANSI SGR color sequences with colored character output.
// ----------------------------------------------------------------------------
// Usage:
//   Raw terminal output enters one byte per word on the s_* stream. Bytes that
//   belong to an ESC [ ... sequence, and ESC bytes, are consumed silently;
//   every other byte yields one word on the m_* stream carrying the display
//   code, its kind on m_tuser, and the foreground and background colors in
//   force at that byte. The final 'm' of a sequence updates the colors for
//   the bytes that follow. The result of an accepted byte is registered and
//   shows on the m_* side right after the edge that accepts it. Throughput is
//   one byte per cycle while the receiver keeps up; all the per-byte work is
//   a small state update between the input handshake and the output register.
//   The parameters of a sequence are folded as they arrive: only the first
//   parameter that touches each color is kept, which is the one that wins when
//   the list is applied from last to first. No parameter list is stored.
//   While the receiver stalls, the output register holds its word and s_tready
//   stays low until the word is taken (or is taken in the same cycle).
//   Reset (rst, synchronous) empties the output register, leaves any sequence,
//   and loads both colors and both default registers with their reset values.
//   The default color registers are written over the APB port at 0x0 and 0x4;
//   a write changes only what a later parameter 0 restores.
// ----------------------------------------------------------------------------
module ansi_sgr_color_parser #(
  parameter int MAX_PARAMS = 5
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream. s_tdata: [7:0] in_byte.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // Output stream. m_tdata: [7:0] char_code, [39:8] fg_color, [71:40] bg_color_out.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,
  // m_tuser: [1:0] char_kind.
  output logic [1:0]  m_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Counter width for completed parameters; it counts up to MAX_PARAMS - 1.
  localparam int CW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [CW:0] MAX_P = (CW + 1)'(MAX_PARAMS);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ESC   = 2'd1,
    PH_PARAM = 2'd2
  } phase_t;

  phase_t        phase, phase_next;
  logic [CW-1:0] param_count, param_count_next;
  logic [7:0]    current_value, current_value_next;
  // First parameter of the running list that touches each color.
  logic          fg_hit, fg_hit_next;
  logic [7:0]    fg_code, fg_code_next;
  logic          bg_hit, bg_hit_next;
  logic [7:0]    bg_code, bg_code_next;
  logic [31:0]   cur_fg, cur_fg_next;
  logic [31:0]   cur_bg, cur_bg_next;
  logic [31:0]   default_fg;
  logic [31:0]   default_bg;

  logic          accept;
  logic          emit;
  logic [7:0]    out_code;
  logic [1:0]    out_kind;
  logic [11:0]   acc_wide;
  logic [7:0]    fg_pick;
  logic [7:0]    bg_pick;
  logic          fg_apply;
  logic          bg_apply;
  logic          cfg_write;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = paddr[2] ? default_bg : default_fg;

  // Decimal accumulate with saturation at 255.
  assign acc_wide = ({4'd0, current_value} * 12'd10) + {4'd0, s_tdata - sgr_pkg::CH_ZERO};

  // On the final byte the stored first hit wins, else the last parameter counts.
  assign fg_pick  = fg_hit ? fg_code : current_value;
  assign bg_pick  = bg_hit ? bg_code : current_value;
  assign fg_apply = fg_hit || sgr_pkg::touches_fg(current_value);
  assign bg_apply = bg_hit || sgr_pkg::touches_bg(current_value);

  always_comb begin
    phase_next         = phase;
    param_count_next   = param_count;
    current_value_next = current_value;
    fg_hit_next        = fg_hit;
    fg_code_next       = fg_code;
    bg_hit_next        = bg_hit;
    bg_code_next       = bg_code;
    cur_fg_next        = cur_fg;
    cur_bg_next        = cur_bg;
    emit               = 1'b0;
    out_code           = 8'd0;
    out_kind           = sgr_pkg::KIND_STOP;

    if (phase == PH_PARAM) begin
      if (s_tdata >= sgr_pkg::CH_ZERO && s_tdata <= sgr_pkg::CH_NINE) begin
        current_value_next = (acc_wide > 12'd255) ? 8'd255 : acc_wide[7:0];
      end else if (s_tdata == sgr_pkg::CH_SEMI && ({1'b0, param_count} + 1'b1) < MAX_P) begin
        if (!fg_hit && sgr_pkg::touches_fg(current_value)) begin
          fg_hit_next  = 1'b1;
          fg_code_next = current_value;
        end
        if (!bg_hit && sgr_pkg::touches_bg(current_value)) begin
          bg_hit_next  = 1'b1;
          bg_code_next = current_value;
        end
        param_count_next   = param_count + 1'b1;
        current_value_next = 8'd0;
      end else begin
        // A separator past MAX_PARAMS parameters, or any byte but 'm', ends the list unapplied.
        if (s_tdata == sgr_pkg::CH_FINAL_M) begin
          if (fg_apply) begin
            cur_fg_next = sgr_pkg::fg_of(fg_pick, default_fg);
          end
          if (bg_apply) begin
            cur_bg_next = sgr_pkg::bg_of(bg_pick, default_bg);
          end
        end
        phase_next         = PH_IDLE;
        param_count_next   = '0;
        current_value_next = 8'd0;
      end
    end else if (phase == PH_ESC && s_tdata == sgr_pkg::CH_LBRACKET) begin
      phase_next         = PH_PARAM;
      param_count_next   = '0;
      current_value_next = 8'd0;
      fg_hit_next        = 1'b0;
      bg_hit_next        = 1'b0;
    end else if (s_tdata == sgr_pkg::CH_ESC) begin
      phase_next = PH_ESC;
    end else begin
      // Ordinary byte, including the byte after an ESC that is not a bracket.
      phase_next = PH_IDLE;
      emit       = 1'b1;
      if (s_tdata == 8'd0 || s_tdata >= sgr_pkg::CH_HIGH) begin
        out_code = 8'd0;
        out_kind = sgr_pkg::KIND_STOP;
      end else if (s_tdata >= sgr_pkg::CH_PRINT_LO) begin
        out_code = s_tdata;
        out_kind = sgr_pkg::KIND_PRINT;
      end else begin
        out_code = sgr_pkg::CH_SUB;
        out_kind = sgr_pkg::KIND_CTRL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      param_count   <= '0;
      current_value <= 8'd0;
      fg_hit        <= 1'b0;
      fg_code       <= 8'd0;
      bg_hit        <= 1'b0;
      bg_code       <= 8'd0;
      cur_fg        <= sgr_pkg::RESET_FG;
      cur_bg        <= sgr_pkg::RESET_BG;
      default_fg    <= sgr_pkg::RESET_FG;
      default_bg    <= sgr_pkg::RESET_BG;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (paddr[2]) begin
          default_bg <= pwdata;
        end else begin
          default_fg <= pwdata;
        end
      end
      // A new word loads the output register; otherwise a taken word empties it.
      if (accept && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        phase         <= phase_next;
        param_count   <= param_count_next;
        current_value <= current_value_next;
        fg_hit        <= fg_hit_next;
        fg_code       <= fg_code_next;
        bg_hit        <= bg_hit_next;
        bg_code       <= bg_code_next;
        cur_fg        <= cur_fg_next;
        cur_bg        <= cur_bg_next;
      end
    end
    // Payload of the output register; the colors are those before this byte.
    if (accept && emit) begin
      m_tdata <= {cur_bg, cur_fg, out_code};
      m_tuser <= out_kind;
    end
  end

endmodule
